### hdl/bbr_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
package bbr_pkg;

  localparam int CH_W       = 8;   // one color channel
  localparam int RGB_W      = 24;  // R, G, B as kept in the line stores
  localparam int CSUM_W     = 10;  // sum of three channel samples
  localparam int SUM_W      = 12;  // sum of nine channel samples
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 4'd1;

  localparam int DIM_RESET = 1024;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // x / 9 == (x * 7282) >> 16 for every x below 32768
  localparam int              DIV9_PROD_W = 25;
  localparam int              DIV9_SHIFT  = 16;
  localparam logic [12:0]     DIV9_MUL    = 13'd7282;
  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [CSUM_W-1:0] r;
    logic [CSUM_W-1:0] g;
    logic [CSUM_W-1:0] b;
  } colsum_t;

  typedef struct packed {
    colsum_t              left;
    colsum_t              centre;
    colsum_t              right;
    logic                 mask_left;
    logic                 mask_right;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic                 done;
  } entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_status_t;

endpackage

### hdl/bbr_front.sv
// Front end: stream counters, line stores, column-sum window, request classification.
module bbr_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [31:0]                       pixel_in,
  input  bbr_pkg::q_status_t                q_status,
  output logic                              push,
  output bbr_pkg::entry_t                   entry
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int XW    = bbr_pkg::COORD_W;
  localparam int CSW   = bbr_pkg::CSUM_W;
  localparam int DW    = bbr_pkg::CFG_DATA_W;
  localparam int RGBW  = bbr_pkg::RGB_W;
  localparam int OW    = bbr_pkg::QCNT_W + 1;
  localparam int RST_W = (MAX_WIDTH < bbr_pkg::DIM_RESET) ? MAX_WIDTH : bbr_pkg::DIM_RESET;
  localparam int RST_H = (MAX_HEIGHT < bbr_pkg::DIM_RESET) ? MAX_HEIGHT : bbr_pkg::DIM_RESET;

  // clamped dimensions, minus one
  logic [CW-1:0] wm1, wm1_new;
  logic [HW-1:0] hm1, hm1_new;

  logic [CW-1:0] in_col, out_col;
  logic [RW-1:0] in_row;
  logic [HW-1:0] out_row;

  logic            accept, cfg_hit;
  logic            r_ge1, r_ge2, emit, done, col_last, ocol_last, orow_last;
  logic [RGBW-1:0] px;

  // stage F1
  logic            f1_valid, f1_ge1, f1_ge2, f1_emit, f1_done, f1_ml, f1_mr;
  logic [CW-1:0]   f1_col;
  logic [RGBW-1:0] f1_px;
  logic [XW-1:0]   f1_x, f1_y;
  logic            f1_fwd;
  logic [RGBW-1:0] f1_fwd_up, f1_fwd_mid;

  logic [RGBW-1:0] upper_mem [MAX_WIDTH];
  logic [RGBW-1:0] middle_mem [MAX_WIDTH];
  logic [RGBW-1:0] upper_rd, middle_rd;
  logic [RGBW-1:0] up_raw, mid_raw, up, mid;

  bbr_pkg::colsum_t win_old, win_new, col_sum;
  logic [OW-1:0]    occ;

  // clamp a written dimension to 1..MAX
  always_comb begin
    if (cfg_data == '0) begin
      wm1_new = '0;
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      wm1_new = CW'(MAX_WIDTH - 1);
    end else begin
      wm1_new = CW'(cfg_data - DW'(1));
    end
    if (cfg_data == '0) begin
      hm1_new = '0;
    end else if (32'(cfg_data) > MAX_HEIGHT) begin
      hm1_new = HW'(MAX_HEIGHT - 1);
    end else begin
      hm1_new = HW'(cfg_data - DW'(1));
    end
  end

  assign cfg_hit = cfg_valid && (cfg_index == bbr_pkg::REG_ACTIVE_WIDTH ||
                                 cfg_index == bbr_pkg::REG_ACTIVE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1 <= CW'(RST_W - 1);
      hm1 <= HW'(RST_H - 1);
    end else if (cfg_valid) begin
      if (cfg_index == bbr_pkg::REG_ACTIVE_WIDTH) begin
        wm1 <= wm1_new;
      end
      if (cfg_index == bbr_pkg::REG_ACTIVE_HEIGHT) begin
        hm1 <= hm1_new;
      end
    end
  end

  // reserve a queue slot for every request in flight
  assign occ      = OW'(q_status.count) + OW'(push);
  assign in_ready = occ < OW'(bbr_pkg::QDEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    r_ge1     = in_row != '0;
    r_ge2     = in_row > RW'(1);
    emit      = r_ge2 || (r_ge1 && in_col != '0);
    col_last  = in_col == wm1;
    ocol_last = out_col == wm1;
    orow_last = out_row == hm1;
    done      = emit && ocol_last && orow_last;
    px        = (in_row <= RW'(hm1) && !action) ? pixel_in[31:8] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (done) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col <= col_last ? '0 : in_col + CW'(1);
        in_row <= col_last ? in_row + RW'(1) : in_row;
        if (emit) begin
          out_col <= ocol_last ? '0 : out_col + CW'(1);
          out_row <= ocol_last ? out_row + HW'(1) : out_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_col     <= in_col;
      f1_ge1     <= r_ge1;
      f1_ge2     <= r_ge2;
      f1_px      <= px;
      f1_emit    <= emit;
      f1_done    <= done;
      f1_ml      <= out_col == '0;
      f1_mr      <= ocol_last;
      f1_x       <= XW'(out_col);
      f1_y       <= XW'(out_row);
      // single-column frames read the entry that F1 writes this cycle
      f1_fwd     <= f1_valid && f1_col == in_col;
      f1_fwd_up  <= mid_raw;
      f1_fwd_mid <= f1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd <= upper_mem[in_col];
    end
    if (f1_valid) begin
      upper_mem[f1_col] <= mid_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      middle_rd <= middle_mem[in_col];
    end
    if (f1_valid) begin
      middle_mem[f1_col] <= f1_px;
    end
  end

  always_comb begin
    up_raw    = f1_fwd ? f1_fwd_up : upper_rd;
    mid_raw   = f1_fwd ? f1_fwd_mid : middle_rd;
    up        = f1_ge2 ? up_raw : '0;
    mid       = f1_ge1 ? mid_raw : '0;
    col_sum.r = CSW'(up[23:16]) + CSW'(mid[23:16]) + CSW'(f1_px[23:16]);
    col_sum.g = CSW'(up[15:8]) + CSW'(mid[15:8]) + CSW'(f1_px[15:8]);
    col_sum.b = CSW'(up[7:0]) + CSW'(mid[7:0]) + CSW'(f1_px[7:0]);
  end

  // window kept as column sums: older, newer, and the column arriving now
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      win_old <= '0;
      win_new <= '0;
    end else if (f1_valid) begin
      if (f1_done) begin
        win_old <= '0;
        win_new <= '0;
      end else begin
        win_old <= win_new;
        win_new <= col_sum;
      end
    end
  end

  assign push = f1_valid && f1_emit;

  always_comb begin
    entry.left       = win_old;
    entry.centre     = win_new;
    entry.right      = col_sum;
    entry.mask_left  = f1_ml;
    entry.mask_right = f1_mr;
    entry.x          = f1_x;
    entry.y          = f1_y;
    entry.done       = f1_done;
  end

endmodule

### hdl/bbr_queue.sv
// Short request queue between the front end and the arithmetic back end.
module bbr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bbr_pkg::entry_t    entry_in,
  input  logic               pop,
  output bbr_pkg::entry_t    head,
  output bbr_pkg::q_status_t status
);

  localparam int PW = bbr_pkg::QPTR_W;
  localparam int NW = bbr_pkg::QCNT_W;

  bbr_pkg::entry_t slots [bbr_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [NW-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

  assign head         = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = count == '0;

endmodule

### hdl/bbr_back.sv
// Back end: masked window sum, divide by nine, output register.
module bbr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  bbr_pkg::q_status_t               q_status,
  input  bbr_pkg::entry_t                  head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      pixel_out,
  output logic [bbr_pkg::COORD_W-1:0]      out_x,
  output logic [bbr_pkg::COORD_W-1:0]      out_y,
  output logic                             frame_done
);

  localparam int SW  = bbr_pkg::SUM_W;
  localparam int PW  = bbr_pkg::DIV9_PROD_W;
  localparam int CHW = bbr_pkg::CH_W;
  localparam int SH  = bbr_pkg::DIV9_SHIFT;

  logic                          b1_valid, b1_free, out_load;
  logic [SW-1:0]                 b1_r, b1_g, b1_b;
  logic [SW-1:0]                 sum_r, sum_g, sum_b;
  logic [bbr_pkg::COORD_W-1:0]   b1_x, b1_y;
  logic                          b1_done;
  bbr_pkg::colsum_t              lft, rgt;
  logic [PW-1:0]                 prod_r, prod_g, prod_b;

  assign out_load = b1_valid && (!out_valid || out_ready);
  assign b1_free  = !b1_valid || out_load;
  assign pop      = !q_status.empty && b1_free;

  always_comb begin
    lft   = head.mask_left ? '0 : head.left;
    rgt   = head.mask_right ? '0 : head.right;
    sum_r = SW'(lft.r) + SW'(head.centre.r) + SW'(rgt.r);
    sum_g = SW'(lft.g) + SW'(head.centre.g) + SW'(rgt.g);
    sum_b = SW'(lft.b) + SW'(head.centre.b) + SW'(rgt.b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_free) begin
      b1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_r    <= sum_r;
      b1_g    <= sum_g;
      b1_b    <= sum_b;
      b1_x    <= head.x;
      b1_y    <= head.y;
      b1_done <= head.done;
    end
  end

  always_comb begin
    prod_r = PW'(b1_r) * PW'(bbr_pkg::DIV9_MUL);
    prod_g = PW'(b1_g) * PW'(bbr_pkg::DIV9_MUL);
    prod_b = PW'(b1_b) * PW'(bbr_pkg::DIV9_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_out  <= {prod_r[SH +: CHW], prod_g[SH +: CHW], prod_b[SH +: CHW],
                     bbr_pkg::ALPHA_OPAQUE};
      out_x      <= b1_x;
      out_y      <= b1_y;
      frame_done <= b1_done;
    end
  end

endmodule

### hdl/box_blur_3x3_rgb_core.sv
// Path: the request that completes a pixel's window passes F1, the queue, B1 and the output register.
// That request arrives active_width + 1 requests after the pixel; flush requests drain the last line.
// Throughput: one request per cycle while the queue has room, set by one read and one write per line store per cycle.
// Reset: synchronous, active high; width, height go to 1024 (or smaller MAX_*); counters, window clear.
// Line stores get no clearing pass; entries are masked at the top border until written.
module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [31:0]                      pixel_in,
  // blurred pixels
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [31:0]                      pixel_out,
  output logic [bbr_pkg::COORD_W-1:0]      out_x,
  output logic [bbr_pkg::COORD_W-1:0]      out_y,
  output logic                             frame_done
);

  logic               push, pop;
  bbr_pkg::entry_t    entry, head;
  bbr_pkg::q_status_t q_status;

  // the user must write configuration only while idle; the block does not enforce it, so never hold it off
  assign cfg_ready = 1'b1;

  // front: count the raster position, read and update the line stores,
  // slide the window and decide whether this request yields a result
  bbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pixel_in  (pixel_in),
    .q_status  (q_status),
    .push      (push),
    .entry     (entry)
  );

  // decouple: the front keeps taking requests while the output stalls, until the queue is full
  bbr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry_in (entry),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // back: add the unmasked columns, divide by nine, hold the result
  bbr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .out_x      (out_x),
    .out_y      (out_y),
    .frame_done (frame_done)
  );

`ifndef SYNTHESIS
  // the front's slot reservation must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && q_status.count == 3'(bbr_pkg::QDEPTH)))
    else $error("request queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("request queue popped while empty");

  // accepting a request implies a free slot for it next cycle
  a_room_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (q_status.count < 3'(bbr_pkg::QDEPTH)))
    else $error("request accepted without queue room");
`endif

endmodule
